FILE: design/mqtt_pkt_pkg.sv
// Shared types and constants for the MQTT packet deframer.
// No dependencies; imported by every module of the block.
package mqtt_pkt_pkg;

  localparam int unsigned LenWidth   = 29;  // total packet length
  localparam int unsigned RemWidth   = 28;  // remaining-length value
  localparam int unsigned CountWidth = 3;   // remaining-length byte count

  localparam logic [LenWidth-1:0]   MaxPacketReset = 29'd268435460;
  localparam logic [LenWidth-1:0]   AuthLimit      = 29'd1048576;  // 1 MiB
  localparam logic [CountWidth-1:0] MaxLenBytes    = 3'd4;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } mpd_phase_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_LEN_TOO_LONG = 2'd1,
    ERR_UNAUTH_SIZE  = 2'd2,
    ERR_OVER_MAX     = 2'd3
  } mpd_err_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                first_of_packet;
    logic                in_fixed_header;
    logic                last_of_packet;
    logic [3:0]          packet_type;
    logic [LenWidth-1:0] pkt_total_len;
    logic                header_done;
    mpd_err_t            error_code;
    logic                dropped;
  } mpd_result_t;

endpackage

FILE: design/mqtt_pkt_core.sv
// Deframer state and per-byte decode: phase tracking, remaining-length
// accumulation and limit checks. Depends on mqtt_pkt_pkg.
module mqtt_pkt_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [7:0]                        data_byte,
  input  logic                              check_auth_limit,
  input  logic [mqtt_pkt_pkg::LenWidth-1:0] max_packet_size,
  output mqtt_pkt_pkg::mpd_result_t         result
);
  import mqtt_pkt_pkg::*;

  mpd_phase_t            phase, phase_next;
  logic [RemWidth-1:0]   length_accumulator, length_accumulator_next;
  logic [CountWidth-1:0] length_byte_count, length_byte_count_next;
  logic [RemWidth-1:0]   body_bytes_left, body_bytes_left_next;
  logic [3:0]            current_type, current_type_next;
  logic [LenWidth-1:0]   total_length, total_length_next;
  mpd_err_t              sticky_error, sticky_error_next;

  logic [RemWidth-1:0]   len_shifted;
  logic [RemWidth-1:0]   acc_sum;
  logic [CountWidth-1:0] cnt_inc;
  logic [LenWidth-1:0]   total_calc;
  logic [RemWidth-1:0]   body_dec;
  logic                  cont;
  logic                  auth_fail;
  logic                  max_fail;
  logic                  too_long;

  // 7-bit group placed by its index, least significant group first
  always_comb begin
    case (length_byte_count[1:0])
      2'd0:    len_shifted = {21'b0, data_byte[6:0]};
      2'd1:    len_shifted = {14'b0, data_byte[6:0], 7'b0};
      2'd2:    len_shifted = {7'b0, data_byte[6:0], 14'b0};
      2'd3:    len_shifted = {data_byte[6:0], 21'b0};
      default: len_shifted = '0;
    endcase
  end

  assign cont       = data_byte[7];
  assign acc_sum    = length_accumulator + len_shifted;
  assign cnt_inc    = length_byte_count + 3'd1;
  // header adds the type byte plus each length byte
  assign total_calc = {1'b0, acc_sum} + LenWidth'(cnt_inc) + 29'd1;
  assign auth_fail  = check_auth_limit && (total_calc >= AuthLimit);
  assign max_fail   = total_calc > max_packet_size;
  assign too_long   = cnt_inc >= MaxLenBytes;
  assign body_dec   = body_bytes_left - 28'd1;

  // next state
  always_comb begin
    phase_next              = phase;
    length_accumulator_next = length_accumulator;
    length_byte_count_next  = length_byte_count;
    body_bytes_left_next    = body_bytes_left;
    current_type_next       = current_type;
    total_length_next       = total_length;
    sticky_error_next       = sticky_error;
    if (sticky_error == ERR_NONE) begin
      case (phase)
        PH_LEN: begin
          length_accumulator_next = acc_sum;
          length_byte_count_next  = cnt_inc;
          if (cont) begin
            if (too_long) begin
              sticky_error_next = ERR_LEN_TOO_LONG;
            end
          end else begin
            total_length_next = total_calc;
            if (auth_fail) begin
              sticky_error_next = ERR_UNAUTH_SIZE;
            end else if (max_fail) begin
              sticky_error_next = ERR_OVER_MAX;
            end else begin
              body_bytes_left_next = acc_sum;
              phase_next = (acc_sum == '0) ? PH_TYPE : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          body_bytes_left_next = body_dec;
          if (body_dec == '0) begin
            phase_next = PH_TYPE;
          end
        end
        default: begin
          current_type_next       = data_byte[7:4];
          length_accumulator_next = '0;
          length_byte_count_next  = '0;
          body_bytes_left_next    = '0;
          total_length_next       = '0;
          phase_next              = PH_LEN;
        end
      endcase
    end
  end

  // result for the byte being presented
  always_comb begin
    result                 = '0;
    result.out_byte        = data_byte;
    result.packet_type     = current_type_next;
    result.pkt_total_len   = total_length_next;
    result.error_code      = sticky_error_next;
    result.dropped         = (sticky_error != ERR_NONE);
    if (sticky_error == ERR_NONE) begin
      case (phase)
        PH_LEN: begin
          result.in_fixed_header = 1'b1;
          result.header_done     = !cont;
          result.last_of_packet  = !cont && !auth_fail && !max_fail && (acc_sum == '0);
        end
        PH_BODY: begin
          result.last_of_packet = (body_dec == '0);
        end
        default: begin
          result.first_of_packet = 1'b1;
          result.in_fixed_header = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TYPE;
      length_accumulator <= '0;
      length_byte_count  <= '0;
      body_bytes_left    <= '0;
      current_type       <= '0;
      total_length       <= '0;
      sticky_error       <= ERR_NONE;
    end else if (accept) begin
      phase              <= phase_next;
      length_accumulator <= length_accumulator_next;
      length_byte_count  <= length_byte_count_next;
      body_bytes_left    <= body_bytes_left_next;
      current_type       <= current_type_next;
      total_length       <= total_length_next;
      sticky_error       <= sticky_error_next;
    end
  end

endmodule

FILE: design/mqtt_pkt_out_reg.sv
// Output register stage with valid/ready flow control; generates the
// input-side ready. Depends on mqtt_pkt_pkg.
module mqtt_pkt_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      accept,
  input  mqtt_pkt_pkg::mpd_result_t result_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mqtt_pkt_pkg::mpd_result_t result_out
);
  import mqtt_pkt_pkg::*;

  mpd_result_t held;

  // the slot frees up in the same cycle its transaction leaves
  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign result_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= result_in;
    end
  end

endmodule

FILE: design/mqtt_packet_deframer.sv
// Top level of the MQTT packet deframer: configuration register, decode
// core and output register. Depends on mqtt_pkt_pkg, mqtt_pkt_core and
// mqtt_pkt_out_reg.
//
// The block takes one byte of an MQTT connection stream per input
// transaction and returns one tagged byte per output transaction, one
// for one, in order. Each byte is marked as packet type byte, fixed-header
// byte, header-closing byte or last byte of the packet, and carries the
// packet type and, once the header closes, the total packet length with
// header included. The remaining-length field is decoded as up to four
// 7-bit groups, least significant first; a fourth length byte with its
// continuation bit set raises error 1. When the header closes, a total of
// 1 MiB or more with check_auth_limit high raises error 2, and otherwise a
// total above max_packet_size raises error 3. Errors are sticky until
// reset: the byte that raises the error is still delivered normally with
// its error_code, and every later byte comes out with dropped set, flags
// cleared and the last type and length held. Throughput is one byte per
// clock: the decode for a byte is done in the cycle it is accepted and the
// result sits in a single output register, and a new transaction is
// taken whenever the output register is empty or being emptied.
// max_packet_size is written through cfg_write_en/cfg_write_data and
// should only change while no transaction is in flight.
module mqtt_packet_deframer (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write_en,
  input  logic [mqtt_pkt_pkg::LenWidth-1:0] cfg_write_data,
  // byte input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              check_auth_limit,
  // tagged byte output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              first_of_packet,
  output logic                              in_fixed_header,
  output logic                              last_of_packet,
  output logic [3:0]                        packet_type,
  output logic [mqtt_pkt_pkg::LenWidth-1:0] pkt_total_len,
  output logic                              header_done,
  output logic [1:0]                        error_code,
  output logic                              dropped
);
  import mqtt_pkt_pkg::*;

  logic [LenWidth-1:0] max_packet_size;
  logic                accept;
  mpd_result_t         core_result;
  mpd_result_t         out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_size <= MaxPacketReset;
    end else if (cfg_write_en) begin
      max_packet_size <= cfg_write_data;
    end
  end

  mqtt_pkt_core u_core (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (data_byte),
    .check_auth_limit (check_auth_limit),
    .max_packet_size  (max_packet_size),
    .result           (core_result)
  );

  mqtt_pkt_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .accept     (accept),
    .result_in  (core_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (out_result)
  );

  assign out_byte        = out_result.out_byte;
  assign first_of_packet = out_result.first_of_packet;
  assign in_fixed_header = out_result.in_fixed_header;
  assign last_of_packet  = out_result.last_of_packet;
  assign packet_type     = out_result.packet_type;
  assign pkt_total_len   = out_result.pkt_total_len;
  assign header_done     = out_result.header_done;
  assign error_code      = out_result.error_code;
  assign dropped         = out_result.dropped;

`ifndef NO_ASSERTIONS
  // a dropped byte always reports the error that caused the drop
  a_drop_has_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> error_code != ERR_NONE)
    else $error("dropped byte without error code");

  // the type byte never closes the header and is always a header byte
  a_first_is_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_of_packet |-> in_fixed_header && !header_done && !dropped)
    else $error("type byte flags inconsistent");

  // header_done only on a length byte
  a_done_in_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done |-> in_fixed_header && !first_of_packet)
    else $error("header_done outside fixed header");

  // once an error has been delivered it stays on every later transaction
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && error_code != ERR_NONE
    |=> !out_valid || error_code == $past(error_code))
    else $error("sticky error changed");
`endif

endmodule
